// ===== hw/rtl/lts_pkg.sv =====
`timescale 1ns / 1ps

package lts_pkg;

  localparam int unsigned TIME_W       = 64;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned REQ_W        = 64;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned WIRE_W       = 16;
  localparam int unsigned HDR_W        = 32;
  localparam int unsigned CFG_W        = 64;
  localparam int unsigned ADDR_W       = 5;

  localparam int unsigned PAYLOAD_MAX  = 1024;
  localparam int unsigned HEADER_BYTES = 40;
  localparam int unsigned RETRY_PERIOD = 1024;
  localparam int unsigned STALL_W      = $clog2(RETRY_PERIOD);
  localparam int unsigned KIND_MAX     = 2;

  localparam logic [TIME_W-1:0] LATENCY_RST  = TIME_W'(2500);
  localparam logic [TIME_W-1:0] INTERVAL_RST = TIME_W'(2500);

  typedef enum logic [1:0] {
    REG_LINK_LATENCY  = 2'd0,
    REG_SYNC_INTERVAL = 2'd1,
    REG_PORT_OPEN     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_EMPTY      = 3'd0,
    ST_PENDING    = 3'd1,
    ST_DELIVERED  = 3'd2,
    ST_SYNC_SENT  = 3'd3,
    ST_SYNC_QUIET = 3'd4,
    ST_SYNC_FAIL  = 3'd5,
    ST_FAULT      = 3'd6
  } status_e;

  typedef enum logic {
    ACT_POLL = 1'b0,
    ACT_SYNC = 1'b1
  } action_e;

endpackage

// ===== hw/rtl/lookahead_time_sync_port_core.sv =====
`timescale 1ns / 1ps
// Path: an input transfer passes the input register, then the result register;
//   back-to-back transfers give one result per cycle unless out_stall_i holds a result.
// Throughput: one item per cycle, set by the single-pass update of the sync state, unless out_stall_i holds a result.
// Reset: rst_ni clears valids and sync/hold state; link_latency and sync_interval
//   return to 2500 and the port is closed. Held message fields are not reset.
module lookahead_time_sync_port_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lts_pkg::ADDR_W-1:0]        paddr,
  input  logic [lts_pkg::CFG_W-1:0]         pwdata,
  output logic [lts_pkg::CFG_W-1:0]         prdata,
  output logic                              pready,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [lts_pkg::TIME_W-1:0]        now_i,
  input  logic                              wire_present_i,
  input  logic [lts_pkg::WIRE_W-1:0]        wire_bytes_i,
  input  logic [lts_pkg::HDR_W-1:0]         header_bytes_i,
  input  logic [lts_pkg::TIME_W-1:0]        msg_time_i,
  input  logic [lts_pkg::ID_W-1:0]          msg_kind_i,
  input  logic [lts_pkg::ID_W-1:0]          msg_source_i,
  input  logic [lts_pkg::ID_W-1:0]          msg_target_i,
  input  logic [lts_pkg::REQ_W-1:0]         msg_request_i,
  input  logic                              tx_ready_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [lts_pkg::TIME_W-1:0]        out_time_o,
  output logic [lts_pkg::KIND_W-1:0]        out_kind_o,
  output logic [lts_pkg::ID_W-1:0]          out_source_o,
  output logic [lts_pkg::ID_W-1:0]          out_target_o,
  output logic [lts_pkg::REQ_W-1:0]         out_request_o,
  output logic [lts_pkg::LEN_W-1:0]         out_payload_len_o,
  output logic                              send_sync_o,
  output logic [lts_pkg::TIME_W-1:0]        safe_time_o
);

  localparam int unsigned TW = lts_pkg::TIME_W;

  // configuration
  logic [TW-1:0] link_latency_q, sync_interval_q, eff_interval_q;
  logic          port_open_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_latency_q  <= lts_pkg::LATENCY_RST;
      sync_interval_q <= lts_pkg::INTERVAL_RST;
      eff_interval_q  <= (lts_pkg::INTERVAL_RST > lts_pkg::LATENCY_RST) ?
                         lts_pkg::INTERVAL_RST : lts_pkg::LATENCY_RST;
      port_open_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lts_pkg::REG_LINK_LATENCY: begin
          link_latency_q <= pwdata;
          eff_interval_q <= (sync_interval_q > pwdata) ? sync_interval_q : pwdata;
        end
        lts_pkg::REG_SYNC_INTERVAL: begin
          sync_interval_q <= pwdata;
          eff_interval_q  <= (pwdata > link_latency_q) ? pwdata : link_latency_q;
        end
        lts_pkg::REG_PORT_OPEN: begin
          port_open_q <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lts_pkg::REG_LINK_LATENCY:  prdata = link_latency_q;
      lts_pkg::REG_SYNC_INTERVAL: prdata = sync_interval_q;
      lts_pkg::REG_PORT_OPEN:     prdata = {{(lts_pkg::CFG_W-1){1'b0}}, port_open_q};
      default:                    prdata = '0;
    endcase
  end

  // handshake
  logic s_valid_q, out_valid_q;
  logic out_free, s_adv, in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s_adv      = s_valid_q && out_free;
  assign in_stall_o = s_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s_valid_q <= 1'b1;
      end else if (s_adv) begin
        s_valid_q <= 1'b0;
      end
      if (s_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // input register
  logic                          s_action_q, s_present_q, s_tx_ready_q;
  logic [TW-1:0]                 s_now_q, s_mtime_q;
  logic [lts_pkg::WIRE_W-1:0]    s_wbytes_q;
  logic [lts_pkg::HDR_W-1:0]     s_hbytes_q;
  logic [lts_pkg::ID_W-1:0]      s_kind_q, s_source_q, s_target_q;
  logic [lts_pkg::REQ_W-1:0]     s_request_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s_action_q   <= action_i;
      s_now_q      <= now_i;
      s_present_q  <= wire_present_i;
      s_wbytes_q   <= wire_bytes_i;
      s_hbytes_q   <= header_bytes_i;
      s_mtime_q    <= msg_time_i;
      s_kind_q     <= msg_kind_i;
      s_source_q   <= msg_source_i;
      s_target_q   <= msg_target_i;
      s_request_q  <= msg_request_i;
      s_tx_ready_q <= tx_ready_i;
    end
  end

  // sync and hold state
  logic [TW-1:0]                 last_sync_q, last_sync_d;
  logic                          emitted_q, emitted_d;
  logic [lts_pkg::STALL_W-1:0]   stalled_q, stalled_d;
  logic [TW-1:0]                 last_recv_q, last_recv_d;
  logic                          held_valid_q, held_valid_d;
  logic [TW-1:0]                 held_time_q, held_time_d;
  logic                          held_load;
  logic [lts_pkg::KIND_W-1:0]    held_kind_q;
  logic [lts_pkg::ID_W-1:0]      held_source_q, held_target_q;
  logic [lts_pkg::REQ_W-1:0]     held_request_q;
  logic [lts_pkg::LEN_W-1:0]     held_len_q;

  // result next values
  lts_pkg::status_e              status_d;
  logic [TW-1:0]                 time_d;
  logic [lts_pkg::KIND_W-1:0]    kind_d;
  logic [lts_pkg::ID_W-1:0]      source_d, target_d;
  logic [lts_pkg::REQ_W-1:0]     request_d;
  logic [lts_pkg::LEN_W-1:0]     len_d;
  logic                          send_d;
  logic [TW-1:0]                 safe_d;

  logic [TW:0]                   stamp_sum;
  logic [TW:0]                   since_sync;
  logic [TW:0]                   bound_sum;
  logic [TW-1:0]                 recv_t, base_t, bound_t;
  logic                          wire_bad;
  logic [lts_pkg::STALL_W-1:0]   stall_inc;
  logic [lts_pkg::KIND_W-1:0]    w_kind;
  logic [lts_pkg::LEN_W-1:0]     w_len;
  logic                          quiet;

  assign stamp_sum  = {1'b0, s_now_q} + {1'b0, link_latency_q};
  assign since_sync = {1'b0, s_now_q} - {1'b0, last_sync_q};
  assign stall_inc  = (stalled_q == lts_pkg::STALL_W'(lts_pkg::RETRY_PERIOD - 1)) ?
                      '0 : stalled_q + lts_pkg::STALL_W'(1);
  assign wire_bad   = (s_wbytes_q < lts_pkg::WIRE_W'(lts_pkg::HEADER_BYTES)) ||
                      (s_wbytes_q > lts_pkg::WIRE_W'(lts_pkg::HEADER_BYTES +
                                                     lts_pkg::PAYLOAD_MAX)) ||
                      (s_kind_q > lts_pkg::ID_W'(lts_pkg::KIND_MAX)) ||
                      (s_hbytes_q != lts_pkg::HDR_W'(s_wbytes_q));
  assign w_kind     = s_kind_q[lts_pkg::KIND_W-1:0];
  assign w_len      = lts_pkg::LEN_W'(s_wbytes_q - lts_pkg::WIRE_W'(lts_pkg::HEADER_BYTES));

  always_comb begin
    status_d     = lts_pkg::ST_EMPTY;
    time_d       = '0;
    kind_d       = '0;
    source_d     = '0;
    target_d     = '0;
    request_d    = '0;
    len_d        = '0;
    send_d       = 1'b0;
    last_sync_d  = last_sync_q;
    emitted_d    = emitted_q;
    stalled_d    = stalled_q;
    last_recv_d  = last_recv_q;
    held_valid_d = held_valid_q;
    held_time_d  = held_time_q;
    held_load    = 1'b0;
    quiet        = 1'b0;

    if (s_action_q == lts_pkg::ACT_POLL) begin
      if (!port_open_q) begin
        status_d = lts_pkg::ST_EMPTY;
      end else if (held_valid_q) begin
        if (held_time_q > s_now_q) begin
          status_d = lts_pkg::ST_PENDING;
        end else begin
          status_d     = lts_pkg::ST_DELIVERED;
          last_recv_d  = held_time_q;
          held_valid_d = 1'b0;
          time_d       = held_time_q;
          kind_d       = held_kind_q;
          source_d     = held_source_q;
          target_d     = held_target_q;
          request_d    = held_request_q;
          len_d        = held_len_q;
        end
      end else if (!s_present_q || wire_bad) begin
        status_d = lts_pkg::ST_EMPTY;
      end else begin
        last_recv_d = s_mtime_q;
        stalled_d   = '0;
        held_load   = 1'b1;
        if (s_mtime_q > s_now_q) begin
          status_d     = lts_pkg::ST_PENDING;
          held_valid_d = 1'b1;
          held_time_d  = s_mtime_q;
        end else begin
          status_d  = lts_pkg::ST_DELIVERED;
          time_d    = s_mtime_q;
          kind_d    = w_kind;
          source_d  = s_source_q;
          target_d  = s_target_q;
          request_d = s_request_q;
          len_d     = w_len;
        end
      end
    end else begin
      if (!port_open_q) begin
        status_d = lts_pkg::ST_SYNC_FAIL;
      end else if (stamp_sum[TW]) begin
        status_d = lts_pkg::ST_FAULT;
      end else if (emitted_q && since_sync[TW]) begin
        status_d = lts_pkg::ST_FAULT;
      end else begin
        if (emitted_q && (since_sync[TW-1:0] < eff_interval_q)) begin
          if (last_recv_q > s_now_q) begin
            quiet = 1'b1;
          end else begin
            stalled_d = stall_inc;
            quiet     = (stall_inc != '0);
          end
        end
        if (quiet) begin
          status_d = lts_pkg::ST_SYNC_QUIET;
        end else if (!s_tx_ready_q) begin
          status_d = lts_pkg::ST_SYNC_FAIL;
        end else begin
          status_d    = lts_pkg::ST_SYNC_SENT;
          time_d      = stamp_sum[TW-1:0];
          send_d      = 1'b1;
          last_sync_d = s_now_q;
          emitted_d   = 1'b1;
        end
      end
    end
  end

  // safe time from the updated state
  assign recv_t    = held_valid_d ? held_time_d : last_recv_d;
  assign base_t    = emitted_d ? last_sync_d : s_now_q;
  assign bound_sum = {1'b0, base_t} + {1'b0, eff_interval_q};
  assign bound_t   = bound_sum[TW] ? {TW{1'b1}} : bound_sum[TW-1:0];
  assign safe_d    = (recv_t < bound_t) ? recv_t : bound_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sync_q  <= '0;
      emitted_q    <= 1'b0;
      stalled_q    <= '0;
      last_recv_q  <= '0;
      held_valid_q <= 1'b0;
      held_time_q  <= '0;
    end else if (s_adv) begin
      last_sync_q  <= last_sync_d;
      emitted_q    <= emitted_d;
      stalled_q    <= stalled_d;
      last_recv_q  <= last_recv_d;
      held_valid_q <= held_valid_d;
      held_time_q  <= held_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_adv && held_load) begin
      held_kind_q    <= w_kind;
      held_source_q  <= s_source_q;
      held_target_q  <= s_target_q;
      held_request_q <= s_request_q;
      held_len_q     <= w_len;
    end
  end

  // result register
  logic [2:0]                    status_q;
  logic [TW-1:0]                 time_q, safe_q;
  logic [lts_pkg::KIND_W-1:0]    kind_q;
  logic [lts_pkg::ID_W-1:0]      source_q, target_q;
  logic [lts_pkg::REQ_W-1:0]     request_q;
  logic [lts_pkg::LEN_W-1:0]     len_q;
  logic                          send_q;

  always_ff @(posedge clk_i) begin
    if (s_adv) begin
      status_q  <= status_d;
      time_q    <= time_d;
      kind_q    <= kind_d;
      source_q  <= source_d;
      target_q  <= target_d;
      request_q <= request_d;
      len_q     <= len_d;
      send_q    <= send_d;
      safe_q    <= safe_d;
    end
  end

  assign status_o          = status_q;
  assign out_time_o        = time_q;
  assign out_kind_o        = kind_q;
  assign out_source_o      = source_q;
  assign out_target_o      = target_q;
  assign out_request_o     = request_q;
  assign out_payload_len_o = len_q;
  assign send_sync_o       = send_q;
  assign safe_time_o       = safe_q;

  // assertions
  a_send_only_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_sync_o |-> status_o == lts_pkg::ST_SYNC_SENT)
    else $error("heartbeat flagged without sync-sent status");

  a_delivered_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && status_o == lts_pkg::ST_DELIVERED |-> !held_valid_q)
    else $error("message delivered while a message is still held");

  a_emitted_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(emitted_q))
    else $error("sync emitted flag cleared outside reset");

  a_stall_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [lts_pkg::TIME_W-1:0] T_MAX = '1;

  typedef struct {
    lts_pkg::action_e           act;
    logic [lts_pkg::TIME_W-1:0] now;
    logic                       present;
    logic [lts_pkg::WIRE_W-1:0] wbytes;
    logic [lts_pkg::HDR_W-1:0]  hbytes;
    logic [lts_pkg::TIME_W-1:0] mtime;
    logic [lts_pkg::ID_W-1:0]   mkind;
    logic [lts_pkg::ID_W-1:0]   src;
    logic [lts_pkg::ID_W-1:0]   tgt;
    logic [lts_pkg::REQ_W-1:0]  req;
    logic                       tx_rdy;
  } port_item_t;

  typedef struct {
    lts_pkg::status_e           status;
    logic [lts_pkg::TIME_W-1:0] stamp;
    logic [lts_pkg::KIND_W-1:0] kind;
    logic [lts_pkg::ID_W-1:0]   src;
    logic [lts_pkg::ID_W-1:0]   tgt;
    logic [lts_pkg::REQ_W-1:0]  req;
    logic [lts_pkg::LEN_W-1:0]  plen;
    logic                       send;
    logic [lts_pkg::TIME_W-1:0] safe;
  } port_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [lts_pkg::ADDR_W-1:0] paddr   = '0;
  logic [lts_pkg::CFG_W-1:0]  pwdata  = '0;
  logic [lts_pkg::CFG_W-1:0]  prdata;
  logic                       pready;

  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic                       action_i       = 1'b0;
  logic [lts_pkg::TIME_W-1:0] now_i          = '0;
  logic                       wire_present_i = 1'b0;
  logic [lts_pkg::WIRE_W-1:0] wire_bytes_i   = '0;
  logic [lts_pkg::HDR_W-1:0]  header_bytes_i = '0;
  logic [lts_pkg::TIME_W-1:0] msg_time_i     = '0;
  logic [lts_pkg::ID_W-1:0]   msg_kind_i     = '0;
  logic [lts_pkg::ID_W-1:0]   msg_source_i   = '0;
  logic [lts_pkg::ID_W-1:0]   msg_target_i   = '0;
  logic [lts_pkg::REQ_W-1:0]  msg_request_i  = '0;
  logic                       tx_ready_i     = 1'b0;

  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic [2:0]                 status_o;
  logic [lts_pkg::TIME_W-1:0] out_time_o;
  logic [lts_pkg::KIND_W-1:0] out_kind_o;
  logic [lts_pkg::ID_W-1:0]   out_source_o;
  logic [lts_pkg::ID_W-1:0]   out_target_o;
  logic [lts_pkg::REQ_W-1:0]  out_request_o;
  logic [lts_pkg::LEN_W-1:0]  out_payload_len_o;
  logic                       send_sync_o;
  logic [lts_pkg::TIME_W-1:0] safe_time_o;

  lookahead_time_sync_port_core dut (.*);

  // endpoint shadow state
  logic [lts_pkg::TIME_W-1:0] cfg_latency  = lts_pkg::LATENCY_RST;
  logic [lts_pkg::TIME_W-1:0] cfg_interval = lts_pkg::INTERVAL_RST;
  logic                       cfg_open     = 1'b0;
  logic [lts_pkg::TIME_W-1:0] sync_base    = '0;
  logic                       sync_sent    = 1'b0;
  int unsigned                stall_cnt    = 0;
  logic [lts_pkg::TIME_W-1:0] recv_stamp   = '0;
  logic                       hold_valid   = 1'b0;
  logic [lts_pkg::TIME_W-1:0] hold_stamp   = '0;
  logic [lts_pkg::KIND_W-1:0] hold_kind    = '0;
  logic [lts_pkg::ID_W-1:0]   hold_src     = '0;
  logic [lts_pkg::ID_W-1:0]   hold_tgt     = '0;
  logic [lts_pkg::REQ_W-1:0]  hold_req     = '0;
  logic [lts_pkg::LEN_W-1:0]  hold_len     = '0;

  port_item_t   poll_sync_q[$];
  port_result_t port_outcome_q[$];
  port_item_t   in_flight;
  port_result_t arrived;

  int          n_queued    = 0;
  int          n_accepted  = 0;
  int          n_cfg       = 0;
  int          errors      = 0;
  int          status_hits[8];
  int          issue_gap   = 0;
  int          burst_left  = 0;
  int          stall_left  = 0;
  int          calm_left   = 0;
  logic [lts_pkg::TIME_W-1:0] t_now = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic port_result_t advance_endpoint(port_item_t it);
    port_result_t               r;
    logic [lts_pkg::TIME_W-1:0] eff, recv, base, bound;
    logic                       due;
    r.status = lts_pkg::ST_EMPTY;
    r.stamp  = '0;
    r.kind   = '0;
    r.src    = '0;
    r.tgt    = '0;
    r.req    = '0;
    r.plen   = '0;
    r.send   = 1'b0;
    due      = 1'b0;
    eff = (cfg_interval > cfg_latency) ? cfg_interval : cfg_latency;
    if (it.act == lts_pkg::ACT_POLL) begin
      if (!cfg_open) begin
        r.status = lts_pkg::ST_EMPTY;
      end else if (hold_valid) begin
        if (hold_stamp > it.now) begin
          r.status = lts_pkg::ST_PENDING;
        end else begin
          recv_stamp = hold_stamp;
          hold_valid = 1'b0;
          r.status   = lts_pkg::ST_DELIVERED;
          r.stamp    = hold_stamp;
          r.kind     = hold_kind;
          r.src      = hold_src;
          r.tgt      = hold_tgt;
          r.req      = hold_req;
          r.plen     = hold_len;
        end
      end else if (it.present && it.wbytes >= lts_pkg::HEADER_BYTES &&
                   it.wbytes <= lts_pkg::HEADER_BYTES + lts_pkg::PAYLOAD_MAX &&
                   it.mkind <= lts_pkg::KIND_MAX &&
                   it.hbytes == lts_pkg::HDR_W'(it.wbytes)) begin
        recv_stamp = it.mtime;
        stall_cnt  = 0;
        hold_kind  = lts_pkg::KIND_W'(it.mkind);
        hold_src   = it.src;
        hold_tgt   = it.tgt;
        hold_req   = it.req;
        hold_len   = lts_pkg::LEN_W'(it.wbytes - lts_pkg::HEADER_BYTES);
        if (it.mtime > it.now) begin
          hold_valid = 1'b1;
          hold_stamp = it.mtime;
          r.status   = lts_pkg::ST_PENDING;
        end else begin
          r.status = lts_pkg::ST_DELIVERED;
          r.stamp  = it.mtime;
          r.kind   = hold_kind;
          r.src    = hold_src;
          r.tgt    = hold_tgt;
          r.req    = hold_req;
          r.plen   = hold_len;
        end
      end
    end else begin
      if (!cfg_open) begin
        r.status = lts_pkg::ST_SYNC_FAIL;
      end else if (it.now > T_MAX - cfg_latency) begin
        r.status = lts_pkg::ST_FAULT;
      end else if (sync_sent && it.now < sync_base) begin
        r.status = lts_pkg::ST_FAULT;
      end else if (sync_sent && it.now - sync_base < eff) begin
        if (recv_stamp > it.now) begin
          r.status = lts_pkg::ST_SYNC_QUIET;
        end else begin
          stall_cnt = (stall_cnt + 1) % lts_pkg::RETRY_PERIOD;
          if (stall_cnt != 0) r.status = lts_pkg::ST_SYNC_QUIET;
          else due = 1'b1;
        end
      end else begin
        due = 1'b1;
      end
      if (due) begin
        if (!it.tx_rdy) begin
          r.status = lts_pkg::ST_SYNC_FAIL;
        end else begin
          r.status  = lts_pkg::ST_SYNC_SENT;
          r.stamp   = it.now + cfg_latency;
          r.send    = 1'b1;
          sync_base = it.now;
          sync_sent = 1'b1;
        end
      end
    end
    recv   = hold_valid ? hold_stamp : recv_stamp;
    base   = sync_sent ? sync_base : it.now;
    bound  = (base > T_MAX - eff) ? T_MAX : base + eff;
    r.safe = (recv < bound) ? recv : bound;
    return r;
  endfunction

  function automatic int next_issue_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic next_out_stall();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      return 1'b1;
    end
    r = $urandom_range(999);
    if (r < 5) begin
      calm_left = $urandom_range(30, 150);
      return 1'b0;
    end
    if (r < 650) return 1'b0;
    if (r < 950) begin
      stall_left = $urandom_range(0, 2);
      return 1'b1;
    end
    stall_left = $urandom_range(8, 30);
    return 1'b1;
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  function automatic port_item_t mk(lts_pkg::action_e a, logic [lts_pkg::TIME_W-1:0] now,
                                    logic pres, logic [lts_pkg::WIRE_W-1:0] wb,
                                    logic [lts_pkg::HDR_W-1:0] hb,
                                    logic [lts_pkg::TIME_W-1:0] mt,
                                    logic [lts_pkg::ID_W-1:0] kd, logic tx);
    port_item_t it;
    it.act     = a;
    it.now     = now;
    it.present = pres;
    it.wbytes  = wb;
    it.hbytes  = hb;
    it.mtime   = mt;
    it.mkind   = kd;
    it.src     = $urandom;
    it.tgt     = $urandom;
    it.req     = {$urandom, $urandom};
    it.tx_rdy  = tx;
    return it;
  endfunction

  function automatic port_item_t make_item(int step_max, int sync_pct, int msg_pct,
                                           int noise_pct);
    port_item_t it;
    int         r;
    it.act = ($urandom_range(99) < sync_pct) ? lts_pkg::ACT_SYNC : lts_pkg::ACT_POLL;
    r = $urandom_range(99);
    if (r < noise_pct) begin
      it.now = {$urandom, $urandom};
    end else if (r < 2 * noise_pct) begin
      it.now = t_now - lts_pkg::TIME_W'($urandom_range(1, step_max));
    end else if (r < 15) begin
      it.now = t_now;
    end else begin
      it.now = t_now + lts_pkg::TIME_W'($urandom_range(0, step_max));
      t_now  = it.now;
    end
    it.present = ($urandom_range(99) < 88);
    r = $urandom_range(9);
    if (r == 0) it.wbytes = lts_pkg::WIRE_W'(lts_pkg::HEADER_BYTES);
    else if (r == 1)
      it.wbytes = lts_pkg::WIRE_W'(lts_pkg::HEADER_BYTES + lts_pkg::PAYLOAD_MAX);
    else
      it.wbytes = lts_pkg::WIRE_W'(lts_pkg::HEADER_BYTES +
                                   $urandom_range(0, lts_pkg::PAYLOAD_MAX));
    it.hbytes = lts_pkg::HDR_W'(it.wbytes);
    it.mkind  = $urandom_range(0, lts_pkg::KIND_MAX);
    r = $urandom_range(99);
    if (r < 40) it.mtime = it.now - lts_pkg::TIME_W'($urandom_range(0, 4 * step_max));
    else if (r < 55) it.mtime = it.now;
    else if (r < 95) it.mtime = it.now + lts_pkg::TIME_W'($urandom_range(1, 4 * step_max));
    else it.mtime = {$urandom, $urandom};
    it.src    = $urandom;
    it.tgt    = $urandom;
    it.req    = {$urandom, $urandom};
    it.tx_rdy = ($urandom_range(99) < 85);
    if ($urandom_range(99) >= msg_pct) begin
      case ($urandom_range(4))
        0: begin
          it.wbytes = lts_pkg::WIRE_W'($urandom_range(0, lts_pkg::HEADER_BYTES - 1));
          it.hbytes = lts_pkg::HDR_W'(it.wbytes);
        end
        1: begin
          it.wbytes = lts_pkg::WIRE_W'($urandom_range(
                        lts_pkg::HEADER_BYTES + lts_pkg::PAYLOAD_MAX + 1, 65535));
          it.hbytes = lts_pkg::HDR_W'(it.wbytes);
        end
        2: begin
          it.mkind = $urandom;
          if (it.mkind <= lts_pkg::KIND_MAX) it.mkind = lts_pkg::KIND_MAX + 1;
        end
        3: it.hbytes = it.hbytes ^ (32'd1 << $urandom_range(0, 31));
        default: begin
          it.wbytes = lts_pkg::WIRE_W'($urandom);
          it.hbytes = $urandom;
          it.mtime  = {$urandom, $urandom};
          it.mkind  = $urandom;
        end
      endcase
    end
    return it;
  endfunction

  task automatic queue_item(port_item_t it);
    poll_sync_q.push_back(it);
    n_queued++;
  endtask

  task automatic drain_port();
    while (n_accepted != n_queued || port_outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(lts_pkg::reg_idx_e idx, logic [lts_pkg::CFG_W-1:0] val);
    logic [lts_pkg::CFG_W-1:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lts_pkg::REG_LINK_LATENCY: begin
        cfg_latency = val;
        want        = val;
      end
      lts_pkg::REG_SYNC_INTERVAL: begin
        cfg_interval = val;
        want         = val;
      end
      default: begin
        cfg_open = val[0];
        want     = lts_pkg::CFG_W'(val[0]);
      end
    endcase
    n_cfg++;
    check_field("register readback", want, prdata);
  endtask

  task automatic run_phase(int n, logic [lts_pkg::TIME_W-1:0] lat,
                           logic [lts_pkg::TIME_W-1:0] ivl,
                           logic [lts_pkg::TIME_W-1:0] start, int step_max, int sync_pct,
                           int msg_pct, int noise_pct);
    cfg_write(lts_pkg::REG_LINK_LATENCY, lat);
    cfg_write(lts_pkg::REG_SYNC_INTERVAL, ivl);
    t_now = start;
    repeat (n) queue_item(make_item(step_max, sync_pct, msg_pct, noise_pct));
    drain_port();
  endtask

  // input side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        port_outcome_q.push_back(advance_endpoint(in_flight));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (issue_gap > 0) begin
          issue_gap--;
          in_valid_i <= 1'b0;
        end else if (poll_sync_q.size() != 0) begin
          in_flight = poll_sync_q.pop_front();
          action_i       <= in_flight.act;
          now_i          <= in_flight.now;
          wire_present_i <= in_flight.present;
          wire_bytes_i   <= in_flight.wbytes;
          header_bytes_i <= in_flight.hbytes;
          msg_time_i     <= in_flight.mtime;
          msg_kind_i     <= in_flight.mkind;
          msg_source_i   <= in_flight.src;
          msg_target_i   <= in_flight.tgt;
          msg_request_i  <= in_flight.req;
          tx_ready_i     <= in_flight.tx_rdy;
          in_valid_i     <= 1'b1;
          issue_gap = next_issue_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (port_outcome_q.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t: transfer with status %0d arrived, none expected",
                     $time, status_o);
        end else begin
          arrived = port_outcome_q.pop_front();
          check_field("status", 64'(arrived.status), 64'(status_o));
          check_field("out_time", arrived.stamp, out_time_o);
          check_field("out_kind", 64'(arrived.kind), 64'(out_kind_o));
          check_field("out_source", 64'(arrived.src), 64'(out_source_o));
          check_field("out_target", 64'(arrived.tgt), 64'(out_target_o));
          check_field("out_request", arrived.req, out_request_o);
          check_field("out_payload_len", 64'(arrived.plen), 64'(out_payload_len_o));
          check_field("send_sync", 64'(arrived.send), 64'(send_sync_o));
          check_field("safe_time", arrived.safe, safe_time_o);
          status_hits[arrived.status]++;
        end
      end
      out_stall_i <= next_out_stall();
    end
  end

  initial begin
    port_item_t it;
    rst_ni <= 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // port still closed after reset
    queue_item(mk(lts_pkg::ACT_POLL, 64'd100, 1'b1, 16'd60, 32'd60, 64'd50, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd100, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    drain_port();
    cfg_write(lts_pkg::REG_PORT_OPEN, 64'd1);

    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b0, 16'd60, 32'd60, 64'd9000, 32'd0,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b1, 16'd39, 32'd39, 64'd9000, 32'd0,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b1, 16'd1065, 32'd1065, 64'd9000, 32'd0,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b1, 16'd60, 32'd60, 64'd9000, 32'd3,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b1, 16'd60, 32'd61, 64'd9000, 32'd0,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b1, 16'd40, 32'd40, 64'd9000, 32'd0,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd10000, 1'b1, 16'd1064, 32'd1064, 64'd20000,
                  32'd2, 1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd15000, 1'b1, 16'd50, 32'd50, 64'd1, 32'd1, 1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd20000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd20000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b0));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd20000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd21000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd19000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, T_MAX, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd21000, 1'b1, 16'd100, 32'd100, 64'd30000, 32'd1,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd21500, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd30000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd22500, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b1));
    it = mk(lts_pkg::ACT_POLL, 64'd30000, 1'b1, 16'd1064, 32'd1064, 64'd30000, 32'd1, 1'b1);
    it.src = '1;
    it.tgt = '1;
    it.req = '1;
    queue_item(it);
    queue_item(mk(lts_pkg::ACT_POLL, 64'd30000, 1'b1, 16'hFFFF, 32'hFFFF, 64'd0, 32'd0,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_POLL, 64'd30000, 1'b1, 16'd80, 32'd80, 64'd0, 32'hFFFF_FFFF,
                  1'b1));
    queue_item(mk(lts_pkg::ACT_SYNC, 64'd23000, 1'b0, 16'd0, 32'd0, 64'd0, 32'd0, 1'b0));
    queue_item(mk(lts_pkg::ACT_POLL, T_MAX, 1'b1, 16'd40, 32'd40, T_MAX, 32'd0, 1'b1));
    drain_port();

    run_phase(100, 64'd2500, 64'd2500, 64'd100000, 3000, 45, 50, 2);
    run_phase(50, 64'd0, 64'd0, 64'h0000_0100_0000_0000, 50, 50, 50, 2);
    run_phase(40, T_MAX - 64'd255, 64'd0, 64'd0, 40, 50, 40, 2);
    // long interval: quiet requests pile up until the periodic resend
    run_phase(1100, 64'd100, T_MAX, 64'h4000_0000_0000_0000, 200, 98, 0, 1);
    cfg_write(lts_pkg::REG_PORT_OPEN, 64'd0);
    run_phase(20, 64'd2500, 64'd2500, 64'h4000_0001_0000_0000, 500, 50, 60, 2);
    cfg_write(lts_pkg::REG_PORT_OPEN, 64'd1);
    run_phase(60, lts_pkg::TIME_W'($urandom_range(0, 5000)),
              lts_pkg::TIME_W'($urandom_range(0, 8000)),
              64'h4000_0002_0000_0000, 1500, 50, 60, 2);

    if (port_outcome_q.size() != 0) begin
      errors += port_outcome_q.size();
      $display("%0t: %0d expected transfers never arrived", $time, port_outcome_q.size());
    end
    $display("Checked %0d transfers across %0d register writes.", n_accepted, n_cfg);
    $display("By status: empty %0d, pending %0d, delivered %0d, sync sent %0d,",
             status_hits[lts_pkg::ST_EMPTY], status_hits[lts_pkg::ST_PENDING],
             status_hits[lts_pkg::ST_DELIVERED], status_hits[lts_pkg::ST_SYNC_SENT]);
    $display("  quiet %0d, sync failed %0d, fault %0d",
             status_hits[lts_pkg::ST_SYNC_QUIET], status_hits[lts_pkg::ST_SYNC_FAIL],
             status_hits[lts_pkg::ST_FAULT]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in the allowed time", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule
